// File: rtl/skt_pkg.sv
// shared types, codes and defaults of the sorted key table
package skt_pkg;

  localparam int DEF_CAPACITY     = 64;
  localparam int DEF_KEY_BITS     = 32;
  localparam int DEF_PAYLOAD_BITS = 16;

  localparam int OPCODE_BITS   = 2;
  localparam int POSITION_BITS = 6;
  localparam int STATUS_BITS   = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } skt_op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } skt_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } skt_cmd_t;

endpackage

// File: rtl/skt_cell.sv
// one table cell: holds a key and payload, shifts towards either neighbour
module skt_cell #(
  parameter int INDEX        = 0,
  parameter int KEY_BITS     = skt_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = skt_pkg::DEF_PAYLOAD_BITS,
  parameter int CMP_W        = 7
) (
  input  logic                    clk,
  input  skt_pkg::skt_cmd_t       cmd,
  input  logic [CMP_W-1:0]        count,
  input  logic [CMP_W-1:0]        pos,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    prev_ins,
  input  logic [KEY_BITS-1:0]     prev_key,
  input  logic [PAYLOAD_BITS-1:0] prev_payload,
  input  logic [KEY_BITS-1:0]     next_key,
  input  logic [PAYLOAD_BITS-1:0] next_payload,
  output logic                    ins,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic [KEY_BITS-1:0]     rd_key,
  output logic [PAYLOAD_BITS-1:0] rd_payload
);
  import skt_pkg::*;

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic occupied;
  logic after_pos;
  logic hit;

  assign occupied  = IDX < count;
  assign after_pos = IDX >= pos;
  assign hit       = occupied && (IDX == pos);

  // new entry goes after every key not greater, so the flag is monotone along the row
  assign ins = !occupied || (key > new_key);

  assign rd_key     = hit ? key : '0;
  assign rd_payload = hit ? payload : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins_en && ins) begin
      if (prev_ins) begin
        key     <= prev_key;
        payload <= prev_payload;
      end else begin
        key     <= new_key;
        payload <= new_payload;
      end
    end else if (cmd.del_en && after_pos && occupied) begin
      key     <= next_key;
      payload <= next_payload;
    end
  end

endmodule

// File: rtl/sorted_key_table_top.sv
// sorted key table: top level with request register, cell row and result register
//
// A table of up to CAPACITY (key, payload) entries kept in ascending unsigned
// key order, built as a row of cells that shift towards their neighbours.
// Requests arrive on the s_ channel: insert in order, delete at a position, or
// read at a position. Every request gives exactly one result on the m_ channel
// with a status, the read key and payload (zero unless a good read), the entry
// count and the empty and full flags after the request.
// An insert goes after all equal keys; a delete closes the gap.
// The request is registered at the transfer; once the output register is free
// or being read, the whole row updates and the result is registered at the same
// edge. One request is in work at a time; s_tready returns once the row has
// updated, so a new request is taken only after the last has left the single
// request register ahead of the row.
// If the receiver stalls, the result waits in the output register and the
// next request is taken and held until the output register frees up.
// Reset empties the table at once (count to zero); no clearing pass is needed.
module sorted_key_table_top #(
  parameter int CAPACITY     = skt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = skt_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = skt_pkg::DEF_PAYLOAD_BITS,
  localparam int CNT_W       = $clog2(CAPACITY + 1),
  localparam int IN_RAW      = skt_pkg::OPCODE_BITS + KEY_BITS + PAYLOAD_BITS
                               + skt_pkg::POSITION_BITS,
  localparam int IN_W        = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW     = skt_pkg::STATUS_BITS + KEY_BITS + PAYLOAD_BITS + CNT_W + 2,
  localparam int OUT_W       = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // opcode, new_key, new_payload, position, zero fill
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status, read_key, read_payload, entry_count, is_empty, is_full, zero fill
  output logic [OUT_W-1:0] m_tdata
);
  import skt_pkg::*;

  localparam int PW    = POSITION_BITS;
  localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;
  localparam int K_LO  = OPCODE_BITS;
  localparam int P_LO  = K_LO + KEY_BITS;
  localparam int POS_LO = P_LO + PAYLOAD_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request register
  logic                    req_valid;
  logic [OPCODE_BITS-1:0]  req_op;
  logic [KEY_BITS-1:0]     req_key;
  logic [PAYLOAD_BITS-1:0] req_payload;
  logic [PW-1:0]           req_pos;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // result register
  logic                    res_valid;
  logic [STATUS_BITS-1:0]  res_status;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [CNT_W-1:0]        res_count;

  logic        exec;
  logic        full;
  logic        pos_bad;
  skt_cmd_t    cmd;
  skt_status_t status;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pos_ext;

  logic [KEY_BITS-1:0]     cell_key     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
  logic [KEY_BITS-1:0]     cell_rd_key  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_rd_pay  [CAPACITY];
  logic [CAPACITY-1:0]     cell_ins;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_payload;

  assign s_tready  = !req_valid;
  assign exec      = req_valid && (!res_valid || m_tready);
  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(req_pos);
  assign full      = count == CAP_CNT;
  assign pos_bad   = pos_ext >= count_ext;

  always_comb begin
    cmd        = '0;
    status     = ST_OK;
    count_next = count;
    case (skt_op_t'(req_op))
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins_en = exec;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_bad) begin
          status = ST_RANGE;
        end else begin
          cmd.del_en = exec;
          count_next = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_bad) begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                    p_ins;
      logic [KEY_BITS-1:0]     p_key;
      logic [PAYLOAD_BITS-1:0] p_pay;
      logic [KEY_BITS-1:0]     n_key;
      logic [PAYLOAD_BITS-1:0] n_pay;

      if (gi == 0) begin : g_first
        assign p_ins = 1'b0;
        assign p_key = req_key;
        assign p_pay = req_payload;
      end else begin : g_mid
        assign p_ins = cell_ins[gi-1];
        assign p_key = cell_key[gi-1];
        assign p_pay = cell_payload[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign n_key = cell_key[gi];
        assign n_pay = cell_payload[gi];
      end else begin : g_inner
        assign n_key = cell_key[gi+1];
        assign n_pay = cell_payload[gi+1];
      end

      skt_cell #(
        .INDEX        (gi),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CMP_W        (CMP_W)
      ) u_cell (
        .clk          (clk),
        .cmd          (cmd),
        .count        (count_ext),
        .pos          (pos_ext),
        .new_key      (req_key),
        .new_payload  (req_payload),
        .prev_ins     (p_ins),
        .prev_key     (p_key),
        .prev_payload (p_pay),
        .next_key     (n_key),
        .next_payload (n_pay),
        .ins          (cell_ins[gi]),
        .key          (cell_key[gi]),
        .payload      (cell_payload[gi]),
        .rd_key       (cell_rd_key[gi]),
        .rd_payload   (cell_rd_pay[gi])
      );
    end
  endgenerate

  // at most one cell matches the position, so the gated outputs just or together
  always_comb begin
    rd_key     = '0;
    rd_payload = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_key     = rd_key | cell_rd_key[i];
      rd_payload = rd_payload | cell_rd_pay[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        req_valid <= 1'b1;
      end else if (exec) begin
        req_valid <= 1'b0;
      end
      if (exec) begin
        res_valid <= 1'b1;
        count     <= count_next;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_op      <= s_tdata[K_LO-1:0];
      req_key     <= s_tdata[P_LO-1:K_LO];
      req_payload <= s_tdata[POS_LO-1:P_LO];
      req_pos     <= s_tdata[POS_LO+PW-1:POS_LO];
    end
    if (exec) begin
      res_status <= status;
      res_count  <= count_next;
      if ((skt_op_t'(req_op) == OP_READ) && !pos_bad) begin
        res_key     <= rd_key;
        res_payload <= rd_payload;
      end else begin
        res_key     <= '0;
        res_payload <= '0;
      end
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = OUT_W'({res_count == CAP_CNT, res_count == '0, res_count,
                            res_payload, res_key, res_status});

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_en |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count by one");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.del_en |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not shrink the count by one");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_count) && $stable(res_status)))
    else $error("stalled result changed");
`endif

endmodule

// File: verif/tb_sorted_key_table_top.sv
// self-checking stream testbench for the sorted key table top level
`timescale 1ns / 100ps

module tb_sorted_key_table_top;
  import skt_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_CAP = 40;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD_CYCLES = 300;

  // fields from the lowest bit up: opcode, new_key, new_payload, position
  typedef struct packed {
    logic [POSITION_BITS-1:0] position;
    logic [15:0]              new_payload;
    logic [31:0]              new_key;
    logic [OPCODE_BITS-1:0]   opcode;
  } request_t;

  // fields from the lowest bit up: status, read_key, read_payload,
  // entry_count, is_empty, is_full, zero fill
  typedef struct packed {
    logic [4:0]             fill;
    logic                   is_full;
    logic                   is_empty;
    logic [6:0]             entry_count;
    logic [15:0]            read_payload;
    logic [31:0]            read_key;
    logic [STATUS_BITS-1:0] status;
  } result_t;

  typedef enum int {FILL_BIASED, DRAIN_BIASED, MIXED} round_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [$bits(request_t)-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [$bits(result_t)-1:0] m_tdata;

  sorted_key_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // predicted table contents
  logic [31:0] key_tab [CAPACITY];
  logic [15:0] pay_tab [CAPACITY];
  int          tab_fill = 0;

  request_t pending_req_q [$];
  result_t  expected_res_q [$];

  int  gen_count = 0;
  int  n_queued = 0;
  int  n_accepted = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  watchdog = 0;
  bit  req_taken = 1'b0;
  bit  idle_on = 1'b1;
  bit  long_hold_done = 1'b0;
  int  tx_gap = 0;
  int  rx_hold = 0;

  logic     drv_valid;
  request_t drv_data;
  logic     rx_ready;

  task automatic table_update(input request_t rq, output result_t rs);
    int slot;
    rs = '0;
    rs.status = ST_OK;
    case (rq.opcode)
      OP_INSERT: begin
        if (tab_fill >= CAPACITY) begin
          rs.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < tab_fill && key_tab[slot] <= rq.new_key) slot++;
          for (int i = tab_fill; i > slot; i--) begin
            key_tab[i] = key_tab[i-1];
            pay_tab[i] = pay_tab[i-1];
          end
          key_tab[slot] = rq.new_key;
          pay_tab[slot] = rq.new_payload;
          tab_fill++;
        end
      end
      OP_DELETE: begin
        if (rq.position >= tab_fill) begin
          rs.status = ST_RANGE;
        end else begin
          for (int i = rq.position; i + 1 < tab_fill; i++) begin
            key_tab[i] = key_tab[i+1];
            pay_tab[i] = pay_tab[i+1];
          end
          tab_fill--;
        end
      end
      OP_READ: begin
        if (rq.position >= tab_fill) begin
          rs.status = ST_RANGE;
        end else begin
          rs.read_key = key_tab[rq.position];
          rs.read_payload = pay_tab[rq.position];
        end
      end
      default: ;
    endcase
    rs.entry_count = 7'(tab_fill);
    rs.is_empty = (tab_fill == 0);
    rs.is_full = (tab_fill == CAPACITY);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // monitor: input transfers feed the prediction, output transfers are checked
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t pred;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (expected_res_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_res_q.pop_front();
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("read_key", want.read_key, got.read_key);
          compare_field("read_payload", 32'(want.read_payload), 32'(got.read_payload));
          compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
          compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
        end
      end
      if (s_tvalid && s_tready) begin
        table_update(request_t'(s_tdata), pred);
        expected_res_q.push_back(pred);
        n_accepted++;
        req_taken = 1'b1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog = 0;
      else watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("** sorted_key_table_top: FAILED **");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    drv_data = s_tdata;
    if (rst) begin
      drv_valid = 1'b0;
    end else if (s_tvalid && !req_taken) begin
      drv_valid = 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap--;
      drv_valid = 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      tx_gap = $urandom_range(1, 9) - 1;
      drv_valid = 1'b0;
    end else if (pending_req_q.size() > 0) begin
      drv_data = pending_req_q.pop_front();
      drv_valid = 1'b1;
    end else begin
      drv_valid = 1'b0;
    end
    req_taken = 1'b0;
    s_tvalid <= drv_valid;
    s_tdata <= drv_data;
  end

  // receiver, with one long hold-off to back the table up
  always @(negedge clk) begin
    if (rst) begin
      rx_ready = 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      rx_hold = LONG_HOLD_CYCLES - 1;
      rx_ready = 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      rx_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      rx_hold = $urandom_range(1, 9) - 1;
      rx_ready = 1'b0;
    end else begin
      rx_ready = 1'b1;
    end
    m_tready <= rx_ready;
  end

  task automatic push_req(input logic [OPCODE_BITS-1:0] op, input logic [31:0] key,
                          input logic [15:0] pay, input logic [POSITION_BITS-1:0] pos);
    request_t rq;
    rq.opcode = op;
    rq.new_key = key;
    rq.new_payload = pay;
    rq.position = pos;
    pending_req_q.push_back(rq);
    n_queued++;
    if (op == OP_INSERT && gen_count < CAPACITY) gen_count++;
    if (op == OP_DELETE && pos < gen_count) gen_count--;
  endtask

  task automatic gen_item(input round_kind_t kind);
    int pick;
    int ins_pct;
    int kpick;
    logic [OPCODE_BITS-1:0] op;
    logic [31:0] key;
    logic [POSITION_BITS-1:0] pos;
    pick = $urandom_range(0, 99);
    ins_pct = (kind == FILL_BIASED) ? 80 : (kind == DRAIN_BIASED) ? 15 : 45;
    if (pick < 8) op = OPCODE_BITS'($urandom_range(0, 3));
    else if ($urandom_range(0, 99) < ins_pct) op = OP_INSERT;
    else if ($urandom_range(0, 1) == 1) op = OP_DELETE;
    else op = OP_READ;
    kpick = $urandom_range(0, 99);
    if (kpick < 10) key = '0;
    else if (kpick < 20) key = '1;
    else if (kpick < 50) key = 32'($urandom_range(0, 15));
    else key = $urandom;
    if (pick < 8 || gen_count == 0) pos = POSITION_BITS'($urandom_range(0, 63));
    else if (gen_count < CAPACITY && $urandom_range(0, 9) == 0)
      pos = POSITION_BITS'($urandom_range(gen_count, CAPACITY - 1));
    else pos = POSITION_BITS'($urandom_range(0, gen_count - 1));
    push_req(op, key, 16'($urandom_range(0, 16'hFFFF)), pos);
  endtask

  task automatic run_phase(input int n_items);
    int made;
    int len;
    round_kind_t kind;
    made = 0;
    while (made < n_items) begin
      kind = round_kind_t'($urandom_range(0, 2));
      len = $urandom_range(40, 140);
      for (int i = 0; i < len && made < n_items; i++) begin
        gen_item(kind);
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_res_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, unused opcode
    push_req(OP_READ, '0, '0, 6'd0);
    push_req(OP_DELETE, '0, '0, 6'd0);
    push_req(OP_READ, '0, '0, 6'd63);
    push_req(OP_UNUSED, '0, '0, 6'd0);
    // key extremes and equal keys in arrival order
    push_req(OP_INSERT, 32'h0, 16'h0, 6'd0);
    push_req(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
    push_req(OP_INSERT, 32'd5, 16'd1, 6'd0);
    push_req(OP_INSERT, 32'd5, 16'd2, 6'd0);
    push_req(OP_INSERT, 32'd5, 16'd3, 6'd0);
    push_req(OP_INSERT, 32'h0, 16'h00AA, 6'd0);
    for (int i = 0; i < 6; i++) push_req(OP_READ, '0, '0, POSITION_BITS'(i));
    push_req(OP_READ, '0, '0, 6'd6);
    // delete last, first and middle
    push_req(OP_DELETE, '0, '0, 6'd5);
    push_req(OP_DELETE, '0, '0, 6'd0);
    push_req(OP_DELETE, '0, '0, 6'd1);
    push_req(OP_READ, '0, '0, 6'd1);
    push_req(OP_UNUSED, '1, '1, '1);
    push_req(OP_READ, '0, '0, 6'd63);
    wait_drained();
    @(posedge clk);

    run_phase(700);
    wait_drained();
    @(posedge clk);

    run_phase(700);
    wait_drained();
    @(posedge clk);

    // last stretch without idling
    idle_on = 1'b0;
    run_phase(200);
    wait_drained();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("** sorted_key_table_top: PASSED **");
    end else begin
      $display("** sorted_key_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sorted_key_table_top.f
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_top.sv
verif/tb_sorted_key_table_top.sv
